>>> hdl/epn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epn_pkg
// Shared constants and command codes for the embedding pooling block.
// ----------------------------------------------------------------------------
package epn_pkg;

    localparam int DEF_MAX_DIM = 1024;
    localparam int DEF_MAX_SEQ = 512;

    localparam int VAL_W   = 16;  // hidden and embedding value width
    localparam int IDX_W   = 10;  // element index port width
    localparam int MODE_W  = 2;
    localparam int SEQ_W   = 10;
    localparam int DIM_W   = 11;
    localparam int CFG_W   = 11;  // widest configuration register
    localparam int CFGI_W  = 2;
    localparam int NUM_W   = 48;  // divider dividend width
    localparam int DEN_W   = 32;  // divider divisor width
    localparam int NORM_W  = 24;  // integer square root of a 48-bit value
    localparam int CMD_DEPTH = 4;

    // configuration register indexes
    localparam logic [CFGI_W-1:0] REG_POOLING_MODE     = 2'd0;
    localparam logic [CFGI_W-1:0] REG_NORMALIZE_ENABLE = 2'd1;
    localparam logic [CFGI_W-1:0] REG_SEQ_LEN          = 2'd2;
    localparam logic [CFGI_W-1:0] REG_DIM_IN_USE       = 2'd3;

    // pooling modes
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MEAN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LAST  = 2'd2;

    // command codes from front to back
    localparam logic [1:0] OP_NOP   = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_ADD   = 2'd2;
    localparam logic [1:0] OP_FETCH = 2'd3;

endpackage

>>> hdl/epn_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epn_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module epn_fifo
    import epn_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_full,
    output logic         o_empty
);
    localparam int PW = $clog2(CMD_DEPTH);
    localparam int CW = $clog2(CMD_DEPTH + 1);

    logic [W-1:0]  r_mem [CMD_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(CMD_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(CMD_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(CMD_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

>>> hdl/epn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epn_front
// Accepts items, tracks token and dimension position, issues commands.
// ----------------------------------------------------------------------------
module epn_front
    import epn_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM,
    parameter int MAX_SEQ = DEF_MAX_SEQ,
    parameter int CMD_W   = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic                    i_kind,
    input  logic signed [VAL_W-1:0] i_hidden_value,
    input  logic                    i_token_valid,
    input  logic [MODE_W-1:0]       i_pooling_mode,
    input  logic                    i_normalize_enable,
    input  logic [SEQ_W-1:0]        i_seq_len,
    input  logic [DIM_W-1:0]        i_dim_in_use,
    output logic                    o_cmd_push,
    output logic [CMD_W-1:0]        o_cmd
);
    localparam int AW  = $clog2(MAX_DIM);
    localparam int TW  = $clog2(MAX_SEQ);
    localparam int DCW = $clog2(MAX_DIM + 1);
    localparam int SCW = $clog2(MAX_SEQ + 1);

    localparam logic PH_LOAD = 1'b0;
    localparam logic PH_READ = 1'b1;

    typedef struct packed {
        logic [1:0]       op;
        logic             flag;   // finalize after a feed, last on a fetch
        logic [AW-1:0]    addr;
        logic [VAL_W-1:0] value;
        logic             mean;
        logic             norm;
        logic [DCW-1:0]   dim;
        logic [SCW-1:0]   vcnt;
    } t_cmd;

    logic           r_phase, n_phase;
    logic [AW-1:0]  r_dim_cnt, n_dim_cnt;
    logic [TW-1:0]  r_tok_cnt, n_tok_cnt;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [SCW-1:0] r_vcnt, n_vcnt;
    logic [DCW-1:0] eff_dim;
    logic [SCW-1:0] eff_seq;
    t_cmd           cmd;
    logic           push;

    always_comb begin
        if (i_dim_in_use == '0) begin
            eff_dim = DCW'(1);
        end else if (32'(i_dim_in_use) > 32'(MAX_DIM)) begin
            eff_dim = DCW'(MAX_DIM);
        end else begin
            eff_dim = DCW'(i_dim_in_use);
        end
        if (i_seq_len == '0) begin
            eff_seq = SCW'(1);
        end else if (32'(i_seq_len) > 32'(MAX_SEQ)) begin
            eff_seq = SCW'(MAX_SEQ);
        end else begin
            eff_seq = SCW'(i_seq_len);
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_dim_cnt = r_dim_cnt;
        n_tok_cnt = r_tok_cnt;
        n_rd_ptr  = r_rd_ptr;
        n_vcnt    = r_vcnt;
        push      = 1'b0;
        cmd.op    = OP_NOP;
        cmd.flag  = 1'b0;
        cmd.addr  = r_dim_cnt;
        cmd.value = i_hidden_value;
        cmd.mean  = !(i_pooling_mode == MODE_FIRST || i_pooling_mode == MODE_LAST);
        cmd.norm  = i_normalize_enable;
        cmd.dim   = eff_dim;
        cmd.vcnt  = r_vcnt;
        if (i_accept && !i_kind && r_phase == PH_LOAD) begin
            push = 1'b1;
            case (i_pooling_mode)
                MODE_FIRST: begin
                    if (r_tok_cnt == '0) cmd.op = OP_WRITE;
                end
                MODE_LAST: begin
                    if (r_tok_cnt == '0 || i_token_valid) cmd.op = OP_WRITE;
                end
                default: begin
                    if (i_token_valid) cmd.op = OP_ADD;
                end
            endcase
            if (r_dim_cnt == '0 && i_token_valid) begin
                n_vcnt = r_vcnt + 1'b1;
            end
            cmd.vcnt = n_vcnt;
            if (DCW'(r_dim_cnt) + 1'b1 >= eff_dim) begin
                n_dim_cnt = '0;
                if (SCW'(r_tok_cnt) + 1'b1 >= eff_seq) begin
                    n_tok_cnt = '0;
                    cmd.flag  = 1'b1;
                    n_phase   = PH_READ;
                    n_rd_ptr  = '0;
                end else begin
                    n_tok_cnt = r_tok_cnt + 1'b1;
                end
            end else begin
                n_dim_cnt = r_dim_cnt + 1'b1;
            end
        end else if (i_accept && i_kind && r_phase == PH_READ) begin
            push     = 1'b1;
            cmd.op   = OP_FETCH;
            cmd.addr = r_rd_ptr;
            if (DCW'(r_rd_ptr) + 1'b1 >= eff_dim) begin
                cmd.flag  = 1'b1;
                n_phase   = PH_LOAD;
                n_rd_ptr  = '0;
                n_vcnt    = '0;
                n_dim_cnt = '0;
                n_tok_cnt = '0;
            end else begin
                n_rd_ptr = r_rd_ptr + 1'b1;
            end
        end
    end

    assign o_cmd_push = push;
    assign o_cmd      = CMD_W'(cmd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LOAD;
            r_dim_cnt <= '0;
            r_tok_cnt <= '0;
            r_rd_ptr  <= '0;
            r_vcnt    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_dim_cnt <= n_dim_cnt;
            r_tok_cnt <= n_tok_cnt;
            r_rd_ptr  <= n_rd_ptr;
            r_vcnt    <= n_vcnt;
        end
    end
endmodule

>>> hdl/epn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epn_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module epn_div
    import epn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   shifted;
    logic             fits;

    assign shifted = {r_rem, r_quo[NUM_W-1]};
    assign fits    = (shifted >= {1'b0, r_den});
    assign o_done  = r_done;
    assign o_quot  = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? DEN_W'(shifted - {1'b0, r_den}) : DEN_W'(shifted);
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

>>> hdl/epn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epn_back
// Executes commands: pooling store updates, finalize sweep, square root,
// element readout and the clearing pass.
// ----------------------------------------------------------------------------
module epn_back
    import epn_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM,
    parameter int MAX_SEQ = DEF_MAX_SEQ,
    parameter int CMD_W   = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_empty,
    input  logic [CMD_W-1:0]         i_cmd,
    output logic                     o_cmd_pop,
    input  logic                     i_pop,
    output logic                     o_empty,
    output logic signed [VAL_W-1:0]  o_embedding_value,
    output logic [$clog2(MAX_DIM)-1:0] o_element_index,
    output logic                     o_last_element,
    output logic                     o_clearing
);
    localparam int AW  = $clog2(MAX_DIM);
    localparam int DCW = $clog2(MAX_DIM + 1);
    localparam int SCW = $clog2(MAX_SEQ + 1);
    localparam int SQ_STEPS = NUM_W / 2;
    localparam int ITW = $clog2(SQ_STEPS);

    typedef struct packed {
        logic [1:0]       op;
        logic             flag;
        logic [AW-1:0]    addr;
        logic [VAL_W-1:0] value;
        logic             mean;
        logic             norm;
        logic [DCW-1:0]   dim;
        logic [SCW-1:0]   vcnt;
    } t_cmd;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_FADD  = 4'd2;
    localparam logic [3:0] S_SRD   = 4'd3;
    localparam logic [3:0] S_SGOT  = 4'd4;
    localparam logic [3:0] S_SDIV  = 4'd5;
    localparam logic [3:0] S_SSQ   = 4'd6;
    localparam logic [3:0] S_SACC  = 4'd7;
    localparam logic [3:0] S_SQRT  = 4'd8;
    localparam logic [3:0] S_XGOT  = 4'd9;
    localparam logic [3:0] S_XDIV  = 4'd10;

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [VAL_W-1:0] sat16(input logic signed [31:0] v);
        if (v > 32'sd32767) return 16'h7FFF;
        if (v < -32'sd32768) return 16'h8000;
        return v[15:0];
    endfunction

    logic signed [31:0] r_mem [MAX_DIM];
    logic signed [31:0] r_rdata;

    logic [3:0]         r_state, n_state;
    t_cmd               r_cmd, n_cmd, head;
    logic [AW-1:0]      r_clr, n_clr;
    logic [AW-1:0]      r_sw, n_sw;
    logic signed [31:0] r_p, n_p;
    logic [NUM_W-1:0]   r_sq, n_sq;
    logic [NUM_W-1:0]   r_sum, n_sum;
    logic [NUM_W-1:0]   r_sv, n_sv;
    logic [NUM_W-1:0]   r_res, n_res;
    logic [NUM_W-1:0]   r_bit, n_bit;
    logic [ITW-1:0]     r_it, n_it;
    logic [NORM_W-1:0]  r_norm, n_norm;
    logic               r_out_valid, n_out_valid;
    logic [VAL_W-1:0]   r_out_val, n_out_val;
    logic [AW-1:0]      r_out_idx, n_out_idx;
    logic               r_out_last, n_out_last;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic signed [31:0] mem_wdata;

    logic               div_start, div_done;
    logic [NUM_W-1:0]   div_num, div_quot;
    logic [DEN_W-1:0]   div_den;

    logic [31:0]        mag;
    logic [63:0]        sq_full;
    logic [NUM_W-1:0]   rb, sum_next;
    logic               can_go, finish;
    logic [VAL_W-1:0]   fin_val;
    logic [16:0]        q17;

    assign head = t_cmd'(i_cmd);

    epn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_clr       = r_clr;
        n_sw        = r_sw;
        n_p         = r_p;
        n_sq        = r_sq;
        n_sum       = r_sum;
        n_sv        = r_sv;
        n_res       = r_res;
        n_bit       = r_bit;
        n_it        = r_it;
        n_norm      = r_norm;
        n_out_valid = r_out_valid;
        n_out_val   = r_out_val;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        mem_waddr   = r_cmd.addr;
        mem_wdata   = '0;
        mem_raddr   = r_cmd.addr;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;
        o_cmd_pop   = 1'b0;
        finish      = 1'b0;
        fin_val     = '0;
        mag         = abs32(r_p);
        sq_full     = 64'(mag) * 64'(mag);
        sum_next    = r_sum + r_sq;
        rb          = r_res + r_bit;
        q17         = 17'(div_quot);
        can_go      = !i_cmd_empty && !(head.op == OP_FETCH && r_out_valid);

        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                if (r_clr == AW'(MAX_DIM - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                mem_raddr = head.addr;
                if (can_go) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = head;
                    case (head.op)
                        OP_WRITE: begin
                            mem_we    = 1'b1;
                            mem_waddr = head.addr;
                            mem_wdata = 32'(signed'(head.value));
                            if (head.flag) begin
                                n_state = S_SRD;
                                n_sw    = '0;
                                n_sum   = '0;
                            end
                        end
                        OP_ADD:   n_state = S_FADD;
                        OP_FETCH: n_state = S_XGOT;
                        default: begin
                            if (head.flag) begin
                                n_state = S_SRD;
                                n_sw    = '0;
                                n_sum   = '0;
                            end
                        end
                    endcase
                end
            end
            S_FADD: begin
                mem_we    = 1'b1;
                mem_wdata = r_rdata + 32'(signed'(r_cmd.value));
                if (r_cmd.flag) begin
                    n_state = S_SRD;
                    n_sw    = '0;
                    n_sum   = '0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SRD: begin
                mem_raddr = r_sw;
                n_state   = S_SGOT;
            end
            S_SGOT: begin
                n_p     = r_rdata;
                n_state = S_SSQ;
                if (r_cmd.mean) begin
                    if (r_cmd.vcnt != '0) begin
                        div_start = 1'b1;
                        div_num   = NUM_W'(abs32(r_rdata)) + NUM_W'(r_cmd.vcnt >> 1);
                        div_den   = DEN_W'(r_cmd.vcnt);
                        n_state   = S_SDIV;
                    end else begin
                        n_p = '0;
                    end
                end
            end
            S_SDIV: begin
                if (div_done) begin
                    n_p     = r_p[31] ? -signed'(div_quot[31:0]) : signed'(div_quot[31:0]);
                    n_state = S_SSQ;
                end
            end
            S_SSQ: begin
                if (r_cmd.mean) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_sw;
                    mem_wdata = r_p;
                end
                n_sq    = sq_full[NUM_W-1:0];
                n_state = S_SACC;
            end
            S_SACC: begin
                n_sum = sum_next;
                if (DCW'(r_sw) + 1'b1 >= r_cmd.dim) begin
                    n_sv    = sum_next;
                    n_res   = '0;
                    n_bit   = NUM_W'(1) << (NUM_W - 2);
                    n_it    = '0;
                    n_state = S_SQRT;
                end else begin
                    n_sw    = r_sw + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_SQRT: begin
                if (r_sv >= rb) begin
                    n_sv  = r_sv - rb;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                n_it  = r_it + 1'b1;
                if (r_it == ITW'(SQ_STEPS - 1)) begin
                    n_norm  = (n_res == '0) ? NORM_W'(1) : n_res[NORM_W-1:0];
                    n_state = S_IDLE;
                end
            end
            S_XGOT: begin
                n_p = r_rdata;
                if (r_cmd.norm) begin
                    div_start = 1'b1;
                    div_num   = (NUM_W'(abs32(r_rdata)) << 15) + NUM_W'(r_norm >> 1);
                    div_den   = DEN_W'(r_norm);
                    n_state   = S_XDIV;
                end else begin
                    finish  = 1'b1;
                    fin_val = sat16(r_rdata);
                end
            end
            S_XDIV: begin
                if (div_done) begin
                    finish = 1'b1;
                    if (r_p[31]) begin
                        fin_val = (div_quot > NUM_W'(32768)) ? 16'h8000
                                                             : 16'(17'd0 - q17);
                    end else begin
                        fin_val = (div_quot > NUM_W'(32767)) ? 16'h7FFF
                                                             : div_quot[VAL_W-1:0];
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (finish) begin
            n_out_valid = 1'b1;
            n_out_val   = fin_val;
            n_out_idx   = r_cmd.addr;
            n_out_last  = r_cmd.flag;
            if (r_cmd.flag) begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end else begin
                n_state = S_IDLE;
            end
        end
    end

    assign o_empty           = !r_out_valid;
    assign o_embedding_value = r_out_val;
    assign o_element_index   = r_out_idx;
    assign o_last_element    = r_out_last;
    assign o_clearing        = (r_state == S_CLEAR);

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_sw      <= n_sw;
        r_p       <= n_p;
        r_sq      <= n_sq;
        r_sum     <= n_sum;
        r_sv      <= n_sv;
        r_res     <= n_res;
        r_bit     <= n_bit;
        r_it      <= n_it;
        r_out_val <= n_out_val;
        r_out_idx <= n_out_idx;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_norm      <= NORM_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_norm      <= n_norm;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

>>> hdl/embedding_pool_normalize_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// embedding_pool_normalize_core
// Pools one sentence of hidden states into an embedding, optionally L2
// normalized, and reads it out element by element.
// ----------------------------------------------------------------------------
// Input queue port (push/full): feed items carry one Q8.8 hidden value with
// its token's mask bit, token-major; fetch items request the next element.
// Result queue port (empty/pop): one element per fetch, with its index and a
// last flag; the result register holds while the receiver stalls, and the
// front keeps taking items into a four-entry command queue meanwhile.
// Configuration: write enable, index and data; write only while idle.
// A feed that writes completes in the idle state; one that accumulates takes
// a read-add-write state. The final feed of a sentence triggers a finalize
// sweep that reads, squares and sums every element (in mean mode each is
// first divided by the valid-token count on the serial 48-step divider),
// then an iterative square root. A normalized fetch divides by the norm on
// the divider. Reset, and the last fetch of every sentence, start a clearing
// pass over every entry of the pooling store; full stays high during it.
// ----------------------------------------------------------------------------
module embedding_pool_normalize_core
    import epn_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM,
    parameter int MAX_SEQ = DEF_MAX_SEQ
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input queue side
    input  logic                    push,
    output logic                    full,
    input  logic                    i_kind,
    input  logic signed [VAL_W-1:0] i_hidden_value,
    input  logic                    i_token_valid,
    // result queue side
    output logic                    empty,
    input  logic                    pop,
    output logic signed [VAL_W-1:0] o_embedding_value,
    output logic [IDX_W-1:0]        o_element_index,
    output logic                    o_last_element,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [CFGI_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_wdata
);
    localparam int AW    = $clog2(MAX_DIM);
    localparam int DCW   = $clog2(MAX_DIM + 1);
    localparam int SCW   = $clog2(MAX_SEQ + 1);
    // command: op, flag, addr, value, mean, norm, dim, valid count
    localparam int CMD_W = 2 + 1 + AW + VAL_W + 1 + 1 + DCW + SCW;

    logic [MODE_W-1:0] r_pooling_mode;
    logic              r_normalize_enable;
    logic [SEQ_W-1:0]  r_seq_len;
    logic [DIM_W-1:0]  r_dim_in_use;

    logic              accept;
    logic              cmd_push, cmd_pop, cmd_full, cmd_empty, clearing;
    logic [CMD_W-1:0]  cmd_wdata, cmd_rdata;
    logic [AW-1:0]     elem_idx;

    // Hold off new items while the command queue is full or the store clears.
    assign full   = cmd_full || clearing;
    assign accept = push && !full;

    // Configuration registers: plain writes, no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pooling_mode     <= MODE_MEAN;
            r_normalize_enable <= 1'b1;
            r_seq_len          <= 10'd256;
            r_dim_in_use       <= 11'd384;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_POOLING_MODE:     r_pooling_mode     <= i_cfg_wdata[MODE_W-1:0];
                REG_NORMALIZE_ENABLE: r_normalize_enable <= i_cfg_wdata[0];
                REG_SEQ_LEN:          r_seq_len          <= i_cfg_wdata[SEQ_W-1:0];
                REG_DIM_IN_USE:       r_dim_in_use       <= i_cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: classify items, advance positions, drop items out of phase.
    epn_front #(
        .MAX_DIM (MAX_DIM),
        .MAX_SEQ (MAX_SEQ),
        .CMD_W   (CMD_W)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_kind             (i_kind),
        .i_hidden_value     (i_hidden_value),
        .i_token_valid      (i_token_valid),
        .i_pooling_mode     (r_pooling_mode),
        .i_normalize_enable (r_normalize_enable),
        .i_seq_len          (r_seq_len),
        .i_dim_in_use       (r_dim_in_use),
        .o_cmd_push         (cmd_push),
        .o_cmd              (cmd_wdata)
    );

    epn_fifo #(
        .W (CMD_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_wdata (cmd_wdata),
        .i_pop   (cmd_pop),
        .o_rdata (cmd_rdata),
        .o_full  (cmd_full),
        .o_empty (cmd_empty)
    );

    // Back: store updates, finalize, readout, clearing.
    epn_back #(
        .MAX_DIM (MAX_DIM),
        .MAX_SEQ (MAX_SEQ),
        .CMD_W   (CMD_W)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_empty       (cmd_empty),
        .i_cmd             (cmd_rdata),
        .o_cmd_pop         (cmd_pop),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_embedding_value (o_embedding_value),
        .o_element_index   (elem_idx),
        .o_last_element    (o_last_element),
        .o_clearing        (clearing)
    );

    assign o_element_index = IDX_W'(elem_idx);
endmodule
